// ----- rtl/srl_pkg.sv -----
// Shared types, character codes and helpers for the S-record stream loader.
// No dependencies; used by srl_parser and srecord_stream_loader.
package srl_pkg;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_SKIP = 3'd1,
      PH_TYPE = 3'd2,
      PH_BODY = 3'd3,
      PH_TAIL = 3'd4
   } srl_phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_FILE   = 2'd2
   } srl_kind_type;

   localparam logic [7:0]  CHAR_LF      = 8'h0A;
   localparam logic [7:0]  CHAR_CR      = 8'h0D;
   localparam logic [7:0]  CHAR_S       = 8'h53;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [3:0]  TYPE_UNKNOWN = 4'hF;
   localparam logic [23:0] TALLY_MAX    = 24'hFF_FFFF;
   localparam logic [7:0]  HEADER_MIN   = 8'd27;

   // error flag bit positions
   localparam int ERR_CHECKSUM  = 0;
   localparam int ERR_HDR_ADDR  = 1;
   localparam int ERR_HDR_SHORT = 2;
   localparam int ERR_LENGTH    = 3;
   localparam int ERR_COUNT     = 4;
   localparam int ERR_DUP_END   = 5;
   localparam int ERR_NO_END    = 6;

   typedef struct packed {
      srl_kind_type kind;
      logic [31:0]  address;
      logic [7:0]   data;
      logic [3:0]   record_type;
      logic [6:0]   error_flags;
      logic         any_fail;
      logic         is_last;
   } srl_result_type;

   // width of the address or count field for a record type
   function automatic logic [2:0] srl_field_len(input logic [3:0] t);
      logic [2:0] len;
      case (t) inside
         4'd0, 4'd1, 4'd5, 4'd9: len = 3'd2;
         4'd2, 4'd6, 4'd8:       len = 3'd3;
         4'd3, 4'd7:             len = 3'd4;
         default:                len = 3'd0;
      endcase
      return len;
   endfunction

   // digits give their low nibble, anything else its low nibble plus 9;
   // the fifth bit carries into the high nibble of a pair
   function automatic logic [4:0] srl_nibble(input logic [7:0] c);
      logic [4:0] v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = {1'b0, c[3:0]};
      end else begin
         v = {1'b0, c[3:0]} + 5'd9;
      end
      return v;
   endfunction

endpackage

// ----- rtl/srl_parser.sv -----
// Record parser: holds the line state and turns one character into up to
// two result items. Depends on srl_pkg.
module srl_parser import srl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     ch,
   input  logic           end_of_input,
   output logic [1:0]     res_count,
   output srl_result_type res0,
   output srl_result_type res1
);

   srl_phase_type parse_phase_ff, parse_phase_in;
   logic [3:0]  type_digit_ff, type_digit_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        nibble_parity_ff, nibble_parity_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [31:0] field_acc_ff, field_acc_in;
   logic [31:0] write_ptr_ff, write_ptr_in;
   logic [23:0] tally_ff, tally_in;
   logic [7:0]  rx_checksum_ff, rx_checksum_in;
   logic        term_seen_ff, term_seen_in;
   logic        fail_ff, fail_in;

   logic [2:0]  field_len;
   logic [7:0]  field_len8;
   logic [4:0]  nib;
   logic [7:0]  cur_byte;
   logic        eol;
   logic        line_open;
   logic        have_ck;
   logic [5:0]  fin_err;
   logic        fin_is_data;
   logic        fin_is_term;
   logic [31:0] fin_run;
   logic [23:0] fin_tally;
   logic        fin_term;
   logic        fin_fail;
   srl_result_type fin_res;

   assign field_len  = srl_field_len(type_digit_ff);
   assign field_len8 = {5'd0, field_len};
   assign nib        = srl_nibble(ch);
   assign cur_byte   = {high_nibble_ff, 4'd0} + {3'd0, nib};
   assign eol        = (ch == CHAR_LF) || (ch == CHAR_CR);
   assign line_open  = (parse_phase_ff == PH_TYPE) || (parse_phase_ff == PH_BODY) ||
                       (parse_phase_ff == PH_TAIL);
   assign have_ck    = (parse_phase_ff == PH_TAIL) ||
                       (parse_phase_ff == PH_BODY && byte_index_ff > byte_count_ff);

   // line-end checks
   always_comb begin
      fin_err     = '0;
      fin_is_data = 1'b0;
      fin_is_term = 1'b0;
      fin_err[ERR_CHECKSUM] = !have_ck || (rx_checksum_ff != ~running_sum_ff);
      case (type_digit_ff) inside
         4'd0: begin
            fin_err[ERR_HDR_ADDR]  = (field_acc_ff != 32'd0);
            fin_err[ERR_HDR_SHORT] = (byte_count_ff < HEADER_MIN);
         end
         4'd1, 4'd2, 4'd3: begin
            fin_is_data = 1'b1;
            fin_err[ERR_LENGTH] = (byte_count_ff < field_len8 + 8'd1);
         end
         4'd5, 4'd6: begin
            if (byte_count_ff != field_len8 + 8'd1) begin
               fin_err[ERR_LENGTH] = 1'b1;
            end else begin
               fin_err[ERR_COUNT] = (field_acc_ff != {8'd0, tally_ff});
            end
         end
         4'd7, 4'd8, 4'd9: begin
            fin_is_term = 1'b1;
            fin_err[ERR_LENGTH]  = (byte_count_ff != field_len8 + 8'd1);
            fin_err[ERR_DUP_END] = term_seen_ff;
         end
         default: begin
         end
      endcase
   end

   assign fin_run   = fin_is_term ? field_acc_ff : 32'd0;
   assign fin_tally = (fin_is_data && tally_ff != TALLY_MAX) ? tally_ff + 24'd1 : tally_ff;
   assign fin_term  = term_seen_ff | fin_is_term;
   assign fin_fail  = fail_ff | (fin_err != 6'd0);

   always_comb begin
      fin_res             = '0;
      fin_res.kind        = KIND_RECORD;
      fin_res.address     = fin_run;
      fin_res.record_type = type_digit_ff;
      fin_res.error_flags = {1'b0, fin_err};
      fin_res.any_fail    = fin_fail;
      fin_res.is_last     = 1'b1;
   end

   always_comb begin
      parse_phase_in   = parse_phase_ff;
      type_digit_in    = type_digit_ff;
      high_nibble_in   = high_nibble_ff;
      nibble_parity_in = nibble_parity_ff;
      byte_index_in    = byte_index_ff;
      byte_count_in    = byte_count_ff;
      running_sum_in   = running_sum_ff;
      field_acc_in     = field_acc_ff;
      write_ptr_in     = write_ptr_ff;
      tally_in         = tally_ff;
      rx_checksum_in   = rx_checksum_ff;
      term_seen_in     = term_seen_ff;
      fail_in          = fail_ff;
      res_count        = 2'd0;
      res0             = '0;
      res1             = '0;

      if (step) begin
         if (end_of_input) begin
            res1             = '0;
            res1.kind        = KIND_FILE;
            res1.record_type = type_digit_ff;
            res1.is_last     = 1'b1;
            if (line_open) begin
               // close the open line first, then report the file
               res0                      = fin_res;
               res0.is_last              = 1'b0;
               res1.error_flags[ERR_NO_END] = !fin_term;
               res1.any_fail             = fin_fail | !fin_term;
               res_count                 = 2'd2;
            end else begin
               res1.error_flags[ERR_NO_END] = !term_seen_ff;
               res1.any_fail             = fail_ff | !term_seen_ff;
               res0                      = res1;
               res_count                 = 2'd1;
            end
            fail_in        = res1.any_fail;
            term_seen_in   = 1'b0;
            tally_in       = '0;
            parse_phase_in = PH_WAIT;
         end else if (parse_phase_ff == PH_WAIT || parse_phase_ff == PH_SKIP) begin
            if (eol) begin
               parse_phase_in = PH_WAIT;
            end else if (parse_phase_ff == PH_WAIT && ch == CHAR_S) begin
               parse_phase_in   = PH_TYPE;
               type_digit_in    = TYPE_UNKNOWN;
               high_nibble_in   = '0;
               nibble_parity_in = 1'b0;
               byte_index_in    = '0;
               byte_count_in    = '0;
               running_sum_in   = '0;
               field_acc_in     = '0;
               write_ptr_in     = '0;
               rx_checksum_in   = '0;
            end else begin
               parse_phase_in = PH_SKIP;
            end
         end else if (eol) begin
            res0           = fin_res;
            res_count      = 2'd1;
            tally_in       = fin_tally;
            term_seen_in   = fin_term;
            fail_in        = fin_fail;
            parse_phase_in = PH_WAIT;
         end else if (parse_phase_ff == PH_TYPE) begin
            type_digit_in  = (ch >= CHAR_ZERO && ch <= CHAR_NINE) ? ch[3:0] : TYPE_UNKNOWN;
            parse_phase_in = PH_BODY;
         end else if (parse_phase_ff == PH_BODY) begin
            if (!nibble_parity_ff) begin
               high_nibble_in   = nib[3:0];
               nibble_parity_in = 1'b1;
            end else begin
               nibble_parity_in = 1'b0;
               if (byte_index_ff == 8'd0) begin
                  byte_count_in = cur_byte;
               end
               if (byte_index_ff < byte_count_in) begin
                  running_sum_in = running_sum_ff + cur_byte;
               end
               if (byte_index_ff == byte_count_in) begin
                  rx_checksum_in = cur_byte;
               end
               if (byte_index_ff >= 8'd1 && byte_index_ff <= field_len8) begin
                  field_acc_in = {field_acc_ff[23:0], cur_byte};
                  if (byte_index_ff == field_len8) begin
                     write_ptr_in = field_acc_in;
                  end
               end
               if (type_digit_ff >= 4'd1 && type_digit_ff <= 4'd3 &&
                   byte_index_ff > field_len8 && byte_index_ff < byte_count_in) begin
                  res0.kind        = KIND_WRITE;
                  res0.address     = write_ptr_ff;
                  res0.data        = cur_byte;
                  res0.record_type = type_digit_ff;
                  res0.any_fail    = fail_ff;
                  res0.is_last     = 1'b1;
                  res_count        = 2'd1;
                  write_ptr_in     = write_ptr_ff + 32'd1;
               end
               // checksum and field both in: ignore the rest of the line
               if (byte_index_ff >= byte_count_in && byte_index_ff >= field_len8) begin
                  parse_phase_in = PH_TAIL;
               end else begin
                  byte_index_in = byte_index_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff   <= PH_WAIT;
         type_digit_ff    <= '0;
         high_nibble_ff   <= '0;
         nibble_parity_ff <= 1'b0;
         byte_index_ff    <= '0;
         byte_count_ff    <= '0;
         running_sum_ff   <= '0;
         field_acc_ff     <= '0;
         write_ptr_ff     <= '0;
         tally_ff         <= '0;
         rx_checksum_ff   <= '0;
         term_seen_ff     <= 1'b0;
         fail_ff          <= 1'b0;
      end else begin
         parse_phase_ff   <= parse_phase_in;
         type_digit_ff    <= type_digit_in;
         high_nibble_ff   <= high_nibble_in;
         nibble_parity_ff <= nibble_parity_in;
         byte_index_ff    <= byte_index_in;
         byte_count_ff    <= byte_count_in;
         running_sum_ff   <= running_sum_in;
         field_acc_ff     <= field_acc_in;
         write_ptr_ff     <= write_ptr_in;
         tally_ff         <= tally_in;
         rx_checksum_ff   <= rx_checksum_in;
         term_seen_ff     <= term_seen_in;
         fail_ff          <= fail_in;
      end
   end

endmodule

// ----- rtl/srecord_stream_loader.sv -----
// Top level of the S-record stream loader: input register, parser and a
// four-entry result queue. Depends on srl_pkg and srl_parser.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_ch, req_end_of_input
//   rsp      out        rsp_valid / rsp_ready  kind, address, data, record_type,
//                                              error_flags, any_fail, is_last
//
// One character is taken per cycle while the queue has room; results are queued.
// End of input on an open line gives two items, and the queue drains at most one
// item per cycle, so the input waits while it holds fewer than two free slots.
// Synchronous reset clears the parser state and empties the input register and queue.
// A stalled rsp side holds results in the queue; req flows until under two slots are free.
module srecord_stream_loader import srl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data,
   output logic [3:0]  rsp_record_type,
   output logic [6:0]  rsp_error_flags,
   output logic        rsp_any_fail,
   output logic        rsp_is_last
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_ch_ff;
   logic        in_eoi_ff;
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   srl_result_type queue_ff [4];

   logic           proceed;
   logic           pop;
   logic [1:0]     res_count;
   srl_result_type res0;
   srl_result_type res1;
   srl_result_type head;

   // advance only with room for the largest burst of results
   assign proceed   = in_valid_ff && (count_ff <= 3'd2);
   assign req_ready = !in_valid_ff || proceed;
   assign pop       = rsp_valid && rsp_ready;

   srl_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (proceed),
      .ch           (in_ch_ff),
      .end_of_input (in_eoi_ff),
      .res_count    (res_count),
      .res0         (res0),
      .res1         (res1)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
      wr_ptr_in = wr_ptr_ff + res_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, res_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_eoi_ff <= req_end_of_input;
      end
      if (res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (res_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_valid       = (count_ff != 3'd0);
   assign rsp_kind        = head.kind;
   assign rsp_address     = head.address;
   assign rsp_data        = head.data;
   assign rsp_record_type = head.record_type;
   assign rsp_error_flags = head.error_flags;
   assign rsp_any_fail    = head.any_fail;
   assign rsp_is_last     = head.is_last;

endmodule
